>>> rtl/prsd_pkg.sv
// ----------------------------------------------------------------------------
// Palette RLE sprite decoder package
// Shared constants, parser phase type and channel expansion functions.
// ----------------------------------------------------------------------------
package prsd_pkg;

	// Default number of palettes held in the palette RAM.
	localparam int PALETTE_COUNT = 4;
	// Entries per palette; the code byte indexes one palette directly.
	localparam int PALETTE_ENTRIES = 256;

	// Stream control codes.
	localparam logic [7:0] CODE_SKIP = 8'hFF;
	localparam logic [7:0] CODE_HALF = 8'hFE;

	// Alpha and channel levels of the output pixels.
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] ALPHA_HALF   = 8'd127;
	localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
	localparam logic [7:0] LEVEL_FULL   = 8'd255;
	localparam logic [7:0] LEVEL_NONE   = 8'd0;

	// Channel expansion v*255/31 and v*255/63, rounded down, done as one
	// constant multiply by 255*ceil(2^20/d) followed by a 20-bit shift.
	localparam logic [28:0] EXP5_MUL = 29'd8625630;
	localparam logic [28:0] EXP6_MUL = 29'd4244475;

	// Parser phases of the image byte stream.
	typedef enum logic [1:0] {
		PH_COUNT,
		PH_SKIP_COUNT,
		PH_HALF_COUNT,
		PH_LITERAL
	} phase_t;

	// Per-beat information carried from the parser to the lookup stage.
	typedef struct packed {
		logic       literal;
		logic       half;
		logic [7:0] count;
		logic       done;
	} res_meta_t;

	// Expand a 5-bit channel to 8 bits.
	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [28:0] p;
		p = 29'(v) * EXP5_MUL;
		return p[27:20];
	endfunction

	// Expand a 6-bit channel to 8 bits.
	function automatic logic [7:0] expand6(input logic [5:0] v);
		logic [28:0] p;
		p = 29'(v) * EXP6_MUL;
		return p[27:20];
	endfunction

endpackage

>>> rtl/palette_rle_sprite_decoder.sv
// ----------------------------------------------------------------------------
// Palette RLE sprite decoder
// Turns a run-length coded sprite byte stream into RGBA pixel beats, with
// literal indices looked up in an RGB565 palette RAM.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock while in_ready is high, palette
// writes and image bytes alike, and gives at most one pixel beat per input
// beat. The accepting edge registers the synchronous palette RAM read into
// the lookup stage, and the expanded channels are then registered into the
// output register once it is free. The palette RAM has one write port
// and one read port, so a palette write and a lookup never compete, and
// a lookup right after a write to the same entry sees the new colour. The
// RAM is not cleared at reset; every palette entry that an image uses must
// be written first.
// palette_select must only change while no image byte is in flight.
module palette_rle_sprite_decoder #(
	parameter int PALETTE_COUNT = prsd_pkg::PALETTE_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration register write.
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	// Input beats.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [9:0]  table_address,
	input  logic [15:0] table_color,
	input  logic [7:0]  code_byte,
	input  logic        end_of_image,
	// Pixel beats.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [7:0]  repeat_res,
	output logic        image_done
);

	localparam int DEPTH = PALETTE_COUNT * prsd_pkg::PALETTE_ENTRIES;
	localparam int AW    = $clog2(DEPTH);

	// Configuration and parser state.
	logic [1:0]       palette_select_q;
	prsd_pkg::phase_t phase_q, phase_d;
	logic [7:0]       literals_q, literals_d;
	logic             half_q, half_d;

	// Handshake and pipeline control.
	logic in_fire;
	logic byte_fire;
	logic out_load;
	logic s1_valid_s1;
	prsd_pkg::res_meta_t meta_s1;
	prsd_pkg::res_meta_t meta_d;
	logic res_valid_d;

	// Palette RAM.
	logic [15:0]   palette_mem [DEPTH];
	logic [15:0]   rdata_s1;
	logic [1:0]    sel_eff;
	logic [AW-1:0] wr_idx;
	logic [AW-1:0] rd_idx;
	logic          wr_en;
	logic          rd_en;

	assign in_fire   = in_valid && in_ready;
	assign byte_fire = in_fire && mode;
	assign out_load  = !out_valid || out_ready;
	assign in_ready  = !s1_valid_s1 || out_load;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_select_q <= '0;
		end else if (cfg_wr_en) begin
			palette_select_q <= cfg_wr_data;
		end
	end

	// Parser next state.
	always_comb begin
		phase_d    = phase_q;
		literals_d = literals_q;
		half_d     = half_q;
		unique case (phase_q)
			prsd_pkg::PH_COUNT: begin
				if (code_byte == prsd_pkg::CODE_SKIP) begin
					phase_d = prsd_pkg::PH_SKIP_COUNT;
				end else if (code_byte == prsd_pkg::CODE_HALF) begin
					phase_d = prsd_pkg::PH_HALF_COUNT;
				end else if (code_byte != '0) begin
					literals_d = code_byte;
					half_d     = 1'b0;
					phase_d    = prsd_pkg::PH_LITERAL;
				end
			end
			prsd_pkg::PH_SKIP_COUNT: begin
				phase_d = prsd_pkg::PH_COUNT;
			end
			prsd_pkg::PH_HALF_COUNT: begin
				half_d     = 1'b1;
				literals_d = code_byte;
				phase_d    = (code_byte != '0) ? prsd_pkg::PH_LITERAL : prsd_pkg::PH_COUNT;
			end
			prsd_pkg::PH_LITERAL: begin
				if (literals_q != '0) begin
					literals_d = literals_q - 8'd1;
				end
				if (literals_q <= 8'd1) begin
					phase_d = prsd_pkg::PH_COUNT;
				end
			end
			default: begin
				phase_d = prsd_pkg::PH_COUNT;
			end
		endcase
		// The last byte of an image always leaves the parser idle.
		if (end_of_image) begin
			phase_d    = prsd_pkg::PH_COUNT;
			literals_d = '0;
			half_d     = 1'b0;
		end
	end

	// Parser outputs: whether this byte yields a pixel, and of what kind.
	always_comb begin
		res_valid_d     = 1'b0;
		meta_d.literal  = 1'b0;
		meta_d.half     = half_q;
		meta_d.count    = code_byte;
		meta_d.done     = end_of_image;
		unique case (phase_q)
			prsd_pkg::PH_SKIP_COUNT: begin
				res_valid_d = (code_byte != '0);
			end
			prsd_pkg::PH_LITERAL: begin
				res_valid_d    = 1'b1;
				meta_d.literal = 1'b1;
			end
			default: begin
				res_valid_d = 1'b0;
			end
		endcase
	end

	// Parser state registers advance on image bytes only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= prsd_pkg::PH_COUNT;
			literals_q <= '0;
			half_q     <= 1'b0;
		end else if (byte_fire) begin
			phase_q    <= phase_d;
			literals_q <= literals_d;
			half_q     <= half_d;
		end
	end

	// Palette addressing; an out-of-range select uses the last palette.
	always_comb begin
		if (32'(palette_select_q) >= PALETTE_COUNT) begin
			sel_eff = 2'(PALETTE_COUNT - 1);
		end else begin
			sel_eff = palette_select_q;
		end
	end

	assign wr_idx = AW'(table_address);
	assign rd_idx = AW'({sel_eff, code_byte});
	assign wr_en  = in_fire && !mode && (32'(table_address) < DEPTH);
	assign rd_en  = byte_fire && (phase_q == prsd_pkg::PH_LITERAL);

	// Palette RAM: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			palette_mem[wr_idx] <= table_color;
		end
		if (rd_en) begin
			rdata_s1 <= palette_mem[rd_idx];
		end
	end

	// Lookup stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			s1_valid_s1 <= byte_fire && res_valid_d;
		end
	end

	// Lookup stage payload.
	always_ff @(posedge clk) begin
		if (byte_fire) begin
			meta_s1 <= meta_d;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= s1_valid_s1;
		end
	end

	// Output register payload: expand literals, or emit a transparent run.
	always_ff @(posedge clk) begin
		if (out_load && s1_valid_s1) begin
			image_done <= meta_s1.done;
			if (meta_s1.literal) begin
				red        <= prsd_pkg::expand5(rdata_s1[15:11]);
				green      <= prsd_pkg::expand6(rdata_s1[10:5]);
				blue       <= prsd_pkg::expand5(rdata_s1[4:0]);
				alpha      <= meta_s1.half ? prsd_pkg::ALPHA_HALF : prsd_pkg::ALPHA_OPAQUE;
				repeat_res <= 8'd1;
			end else begin
				red        <= prsd_pkg::LEVEL_FULL;
				green      <= prsd_pkg::LEVEL_NONE;
				blue       <= prsd_pkg::LEVEL_FULL;
				alpha      <= prsd_pkg::ALPHA_CLEAR;
				repeat_res <= meta_s1.count;
			end
		end
	end

	// A literal phase always has literals pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == prsd_pkg::PH_LITERAL |-> literals_q != '0)
		else $error("literal phase with no literals left");

	// Waiting for a count byte means nothing is pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == prsd_pkg::PH_COUNT |-> literals_q == '0)
		else $error("count phase with literals pending");

	// A full lookup stage behind a stalled output blocks the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while pipeline is full");

	// A transparent run never stands for zero pixels.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alpha == prsd_pkg::ALPHA_CLEAR |-> repeat_res != '0)
		else $error("transparent run with zero repeat");

	// A pixel loaded from the lookup stage appears on the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_s1 && out_load |=> out_valid)
		else $error("pixel lost between lookup and output");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Palette RLE sprite decoder testbench
// Loads RGB565 palettes and streams run-length coded sprite bytes through the
// decoder, with random stalls on both channels. Each pixel beat is compared
// with a local decoder model and a short table of directed beats.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Input beat kinds.
	localparam logic MODE_TABLE = 1'b0;
	localparam logic MODE_IMAGE = 1'b1;

	// Cycles to let the pipeline settle after the last pixel has arrived.
	localparam int PIPE_SETTLE = 6;
	// Cycles without any beat on either channel before the run is abandoned.
	localparam int STALL_LIMIT = 4000;
	// Least number of input beats per random phase.
	localparam int PHASE_BEATS = 255;
	localparam int PHASES = 6;

	typedef struct packed {
		logic        mode;
		logic [9:0]  addr;
		logic [15:0] color;
		logic [7:0]  code;
		logic        eoi;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] rep;
		logic       done;
	} pixel_t;

	// How a directed row is checked.
	typedef enum {
		ROW_PREDICT,
		ROW_QUIET,
		ROW_PIXEL
	} row_kind_t;

	typedef struct {
		row_kind_t kind;
		in_beat_t  beat;
		pixel_t    px;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [9:0]  table_address;
	logic [15:0] table_color;
	logic [7:0]  code_byte;
	logic        end_of_image;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [7:0]  repeat_res;
	logic        image_done;

	palette_rle_sprite_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.table_address(table_address),
		.table_color  (table_color),
		.code_byte    (code_byte),
		.end_of_image (end_of_image),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.repeat_res   (repeat_res),
		.image_done   (image_done)
	);

	// Decoder model state.
	prsd_pkg::phase_t parse_ph;
	logic [7:0]  lits_left;
	logic        half_lits;
	logic [1:0]  pal_sel;
	logic [15:0] palette_shadow [prsd_pkg::PALETTE_COUNT*prsd_pkg::PALETTE_ENTRIES];
	bit          palette_loaded [prsd_pkg::PALETTE_COUNT*prsd_pkg::PALETTE_ENTRIES];

	pixel_t   pending_pixels[$];
	dir_row_t dir_rows[$];
	int       errors = 0;
	int       beats_sent;
	int       snd_idle_pct;
	int       rcv_idle_pct;
	int       idle_cycles;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Expand one colour channel to eight bits, rounding down.
	function automatic logic [7:0] widen(input int v, input int vmax);
		return 8'((v * 255) / vmax);
	endfunction

	// Palette used by literals; an out-of-range select saturates.
	function automatic logic [9:0] literal_base();
		int s;
		s = (int'(pal_sel) >= prsd_pkg::PALETTE_COUNT) ?
			prsd_pkg::PALETTE_COUNT - 1 : int'(pal_sel);
		return 10'(s * prsd_pkg::PALETTE_ENTRIES);
	endfunction

	// Advance the decoder model by one accepted beat; returns 1 with a pixel.
	function automatic bit decode_beat(input in_beat_t b, output pixel_t px);
		bit          hit;
		logic [15:0] c;
		hit = 1'b0;
		px = '0;
		if (b.mode == MODE_TABLE) begin
			if (int'(b.addr) < prsd_pkg::PALETTE_COUNT * prsd_pkg::PALETTE_ENTRIES) begin
				palette_shadow[b.addr] = b.color;
				palette_loaded[b.addr] = 1'b1;
			end
			return 1'b0;
		end
		case (parse_ph)
			prsd_pkg::PH_COUNT: begin
				if (b.code == prsd_pkg::CODE_SKIP) begin
					parse_ph = prsd_pkg::PH_SKIP_COUNT;
				end else if (b.code == prsd_pkg::CODE_HALF) begin
					parse_ph = prsd_pkg::PH_HALF_COUNT;
				end else if (b.code != 8'd0) begin
					lits_left = b.code;
					half_lits = 1'b0;
					parse_ph = prsd_pkg::PH_LITERAL;
				end
			end
			prsd_pkg::PH_SKIP_COUNT: begin
				if (b.code != 8'd0) begin
					px = '{prsd_pkg::LEVEL_FULL, prsd_pkg::LEVEL_NONE, prsd_pkg::LEVEL_FULL,
						prsd_pkg::ALPHA_CLEAR, b.code, b.eoi};
					hit = 1'b1;
				end
				parse_ph = prsd_pkg::PH_COUNT;
			end
			prsd_pkg::PH_HALF_COUNT: begin
				half_lits = 1'b1;
				lits_left = b.code;
				parse_ph = (b.code != 8'd0) ? prsd_pkg::PH_LITERAL : prsd_pkg::PH_COUNT;
			end
			default: begin
				c = palette_shadow[literal_base() + 10'(b.code)];
				px.red   = widen(int'(c[15:11]), 31);
				px.green = widen(int'(c[10:5]), 63);
				px.blue  = widen(int'(c[4:0]), 31);
				px.alpha = half_lits ? prsd_pkg::ALPHA_HALF : prsd_pkg::ALPHA_OPAQUE;
				px.rep   = 8'd1;
				px.done  = b.eoi;
				hit = 1'b1;
				if (lits_left != 8'd0)
					lits_left = lits_left - 8'd1;
				if (lits_left == 8'd0)
					parse_ph = prsd_pkg::PH_COUNT;
			end
		endcase
		if (b.eoi) begin
			parse_ph = prsd_pkg::PH_COUNT;
			lits_left = 8'd0;
			half_lits = 1'b0;
		end
		return hit;
	endfunction

	// Drive one input beat and wait for it to be taken. Called right after a
	// rising edge; returns at the edge that accepted the beat.
	task automatic send_beat(input in_beat_t b, input row_kind_t kind, input pixel_t fixed_px);
		pixel_t px;
		bit     hit;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= b.mode;
		table_address <= b.addr;
		table_color   <= b.color;
		code_byte     <= b.code;
		end_of_image  <= b.eoi;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
		hit = decode_beat(b, px);
		case (kind)
			ROW_PREDICT: if (hit) pending_pixels.push_back(px);
			ROW_PIXEL:   pending_pixels.push_back(fixed_px);
			default:     ;
		endcase
	endtask

	// Palette write with random content in the ignored fields.
	task automatic send_table_write(input logic [9:0] addr, input logic [15:0] color);
		in_beat_t b;
		b = '{MODE_TABLE, addr, color, 8'($urandom), 1'($urandom)};
		send_beat(b, ROW_PREDICT, '0);
	endtask

	// Image byte; a literal index that points at an unwritten palette entry
	// gets that entry loaded first, which also exercises writes mid-run.
	task automatic send_image_byte(input logic [7:0] code, input logic eoi);
		in_beat_t   b;
		logic [9:0] idx;
		idx = literal_base() + 10'(code);
		if (parse_ph == prsd_pkg::PH_LITERAL && !palette_loaded[idx])
			send_table_write(idx, 16'($urandom));
		b = '{MODE_IMAGE, 10'($urandom), 16'($urandom), code, eoi};
		send_beat(b, ROW_PREDICT, '0);
	endtask

	// One well-formed sprite of a few runs, now and then cut short by an
	// early end-of-image flag.
	task automatic send_sprite();
		logic [7:0] img_q[$];
		int         runs;
		int         n;
		int         cut;
		runs = $urandom_range(1, 5);
		repeat (runs) begin
			case ($urandom_range(0, 2))
				0: begin
					n = ($urandom_range(0, 49) == 0) ? $urandom_range(1, 253) : $urandom_range(1, 6);
					img_q.push_back(8'(n));
					repeat (n) img_q.push_back(8'($urandom));
				end
				1: begin
					n = ($urandom_range(0, 49) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
					img_q.push_back(prsd_pkg::CODE_HALF);
					img_q.push_back(8'(n));
					repeat (n) img_q.push_back(8'($urandom));
				end
				default: begin
					img_q.push_back(prsd_pkg::CODE_SKIP);
					img_q.push_back(8'($urandom_range(1, 255)));
				end
			endcase
		end
		cut = img_q.size() - 1;
		if ($urandom_range(0, 9) == 0)
			cut = $urandom_range(0, cut);
		for (int i = 0; i <= cut; i++)
			send_image_byte(img_q[i], i == cut);
	endtask

	// Stop sending and wait until every predicted pixel has come out.
	task automatic drain_pixels();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// Write palette_select; the block must be idle.
	task automatic write_select(input logic [1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pal_sel = v;
	endtask

	function automatic void add_row(input row_kind_t kind, input logic m, input logic [9:0] a,
			input logic [15:0] c, input logic [7:0] code, input logic eoi, input pixel_t px);
		dir_row_t r;
		r.kind = kind;
		r.beat = '{m, a, c, code, eoi};
		r.px = px;
		dir_rows.push_back(r);
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Pixel beat checker and receiver stalls.
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("pixel beat with no pixel expected");
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("red", want.red, red);
				check_field("green", want.green, green);
				check_field("blue", want.blue, blue);
				check_field("alpha", want.alpha, alpha);
				check_field("repeat_res", want.rep, repeat_res);
				check_field("image_done", want.done, image_done);
			end
		end
		out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	// Watchdog on cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		logic [1:0] phase_sel [PHASES];
		int         phase_end;
		int         r;
		logic [7:0] noise;
		phase_sel = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};
		beats_sent = 0;
		snd_idle_pct = 34;
		rcv_idle_pct = 48;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 2'd0;
		in_valid = 1'b0;
		mode = MODE_TABLE;
		table_address = '0;
		table_color = '0;
		code_byte = '0;
		end_of_image = 1'b0;
		parse_ph = prsd_pkg::PH_COUNT;
		lits_left = 8'd0;
		half_lits = 1'b0;
		pal_sel = 2'd0;
		foreach (palette_shadow[i]) begin
			palette_shadow[i] = '0;
			palette_loaded[i] = 1'b0;
		end

		// Directed beats, palette 0 selected from reset.
		add_row(ROW_QUIET, MODE_TABLE, 10'd0, 16'hFFFF, 8'h00, 1'b0, '0);
		// Ignored fields set on a palette write.
		add_row(ROW_QUIET, MODE_TABLE, 10'd1, 16'h0000, prsd_pkg::CODE_SKIP, 1'b1, '0);
		add_row(ROW_QUIET, MODE_TABLE, 10'd2, 16'hF800, 8'h00, 1'b0, '0);
		add_row(ROW_QUIET, MODE_TABLE, 10'd3, 16'h07E0, 8'h00, 1'b0, '0);
		add_row(ROW_QUIET, MODE_TABLE, 10'd1023, 16'h001F, 8'h00, 1'b0, '0);
		// Three opaque literals.
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, 8'd3, 1'b0, '0);
		add_row(ROW_PIXEL, MODE_IMAGE, 10'd0, 16'h0, 8'd0, 1'b0, '{255, 255, 255, 255, 1, 0});
		add_row(ROW_PIXEL, MODE_IMAGE, 10'd0, 16'h0, 8'd1, 1'b0, '{0, 0, 0, 255, 1, 0});
		add_row(ROW_PIXEL, MODE_IMAGE, 10'd0, 16'h0, 8'd2, 1'b0, '{255, 0, 0, 255, 1, 0});
		// Two half-alpha literals with a palette write between them.
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, prsd_pkg::CODE_HALF, 1'b0, '0);
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, 8'd2, 1'b0, '0);
		add_row(ROW_PIXEL, MODE_IMAGE, 10'd0, 16'h0, 8'd3, 1'b0, '{0, 255, 0, 127, 1, 0});
		add_row(ROW_QUIET, MODE_TABLE, 10'd4, 16'h1234, prsd_pkg::CODE_HALF, 1'b1, '0);
		add_row(ROW_PREDICT, MODE_IMAGE, 10'd0, 16'h0, 8'd4, 1'b0, '0);
		// Transparent run of the largest count.
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, prsd_pkg::CODE_SKIP, 1'b0, '0);
		add_row(ROW_PIXEL, MODE_IMAGE, 10'd0, 16'h0, 8'd255, 1'b0, '{255, 0, 255, 0, 255, 0});
		// Zero transparent count, then a zero literal count.
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, prsd_pkg::CODE_SKIP, 1'b0, '0);
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, 8'd0, 1'b0, '0);
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, 8'd0, 1'b0, '0);
		// End of image on a transparent run.
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, prsd_pkg::CODE_SKIP, 1'b0, '0);
		add_row(ROW_PIXEL, MODE_IMAGE, 10'd0, 16'h0, 8'd1, 1'b1, '{255, 0, 255, 0, 1, 1});
		// End of image drops the pending literals of a run.
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, 8'd5, 1'b0, '0);
		add_row(ROW_PIXEL, MODE_IMAGE, 10'd0, 16'h0, 8'd0, 1'b1, '{255, 255, 255, 255, 1, 1});
		// End of image right on a header byte.
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, prsd_pkg::CODE_HALF, 1'b1, '0);
		// Zero half-alpha count returns to the count byte.
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, prsd_pkg::CODE_HALF, 1'b0, '0);
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, 8'd0, 1'b0, '0);
		add_row(ROW_QUIET, MODE_IMAGE, 10'd0, 16'h0, 8'd1, 1'b0, '0);
		add_row(ROW_PIXEL, MODE_IMAGE, 10'd0, 16'h0, 8'd2, 1'b1, '{255, 0, 0, 255, 1, 1});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].beat, dir_rows[i].kind, dir_rows[i].px);
		drain_pixels();

		// Random phases; each selects a palette and a stall profile, with each profile shared by two phases.
		for (int p = 0; p < PHASES; p++) begin
			case (p / 2)
				0: begin
					snd_idle_pct = 34;
					rcv_idle_pct = 48;
				end
				1: begin
					snd_idle_pct = 48;
					rcv_idle_pct = 34;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			write_select(phase_sel[p]);
			phase_end = beats_sent + PHASE_BEATS;
			while (beats_sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					repeat ($urandom_range(1, 4))
						send_table_write(10'($urandom), 16'($urandom));
				end else if (r < 18) begin
					// Stray bytes, biased toward the control codes and zero.
					case ($urandom_range(0, 5))
						0: noise = 8'd0;
						1: noise = prsd_pkg::CODE_HALF;
						2: noise = prsd_pkg::CODE_SKIP;
						default: noise = 8'($urandom);
					endcase
					send_image_byte(noise, $urandom_range(0, 3) == 0);
				end else if (r == 18) begin
					drain_pixels();
				end else begin
					send_sprite();
				end
			end
			drain_pixels();
		end

		if (errors == 0 && pending_pixels.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
